@@ design/xlb_pkg.sv @@
// shared constants and types for the xor linear basis block
`timescale 1ns / 1ps

package xlb_pkg;

   localparam int WORD_BITS_DEFAULT = 31;
   localparam int ACTION_W          = 2;
   localparam int VALUE_W           = 31;
   localparam int MAX_XOR_W         = 31;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   typedef struct packed {
      logic wr_en;
      logic clear_all;
   } xlb_slot_cmd_type;

endpackage

@@ design/xlb_slot_store.sv @@
// basis slot memory with per-slot valid bits and registered read port
`timescale 1ns / 1ps

module xlb_slot_store #(
   parameter int WORD_BITS = xlb_pkg::WORD_BITS_DEFAULT,
   parameter int AW        = $clog2(WORD_BITS)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  xlb_pkg::xlb_slot_cmd_type cmd,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WORD_BITS-1:0]     wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [WORD_BITS-1:0]     rd_data,
   output logic                     rd_valid
);
   import xlb_pkg::*;

   logic [WORD_BITS-1:0] slot_mem [WORD_BITS];
   logic [WORD_BITS-1:0] valid_ff;
   logic [WORD_BITS-1:0] valid_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule

@@ design/xlb_walk.sv @@
// sequencer that walks the slots top down for insert and maximum, and issues the clear
`timescale 1ns / 1ps

module xlb_walk #(
   parameter int WORD_BITS = xlb_pkg::WORD_BITS_DEFAULT,
   parameter int AW        = $clog2(WORD_BITS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [xlb_pkg::ACTION_W-1:0]  start_action,
   input  logic [WORD_BITS-1:0]          start_word,
   output logic                          idle,
   output xlb_pkg::xlb_slot_cmd_type     cmd,
   output logic [AW-1:0]                 wr_addr,
   output logic [WORD_BITS-1:0]          wr_data,
   output logic [AW-1:0]                 rd_addr,
   input  logic [WORD_BITS-1:0]          rd_data,
   input  logic                          rd_valid,
   output logic                          res_valid,
   input  logic                          res_ready,
   output logic [WORD_BITS-1:0]          res_max,
   output logic                          res_added
);
   import xlb_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [AW-1:0] TOP_IDX = AW'(WORD_BITS - 1);

   logic [1:0]           state_ff, state_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [WORD_BITS-1:0] x_ff, x_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic                 ins_ff, ins_in;
   logic                 added_ff, added_in;

   logic                 hit;
   logic                 place;
   logic [WORD_BITS-1:0] eff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      x_in      = x_ff;
      acc_in    = acc_ff;
      ins_in    = ins_ff;
      added_in  = added_ff;
      cmd       = '0;
      idle      = 1'b0;
      res_valid = 1'b0;
      rd_addr   = idx_ff - 1'b1;
      hit       = ins_ff & x_ff[idx_ff];
      place     = hit & ~rd_valid;
      eff       = place ? x_ff : rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            idle    = 1'b1;
            rd_addr = TOP_IDX;
            if (start) begin
               acc_in   = '0;
               added_in = 1'b0;
               if (start_action == ACT_CLEAR) begin
                  cmd.clear_all = 1'b1;
                  state_in      = ST_FINISH;
               end else begin
                  x_in     = start_word;
                  ins_in   = (start_action == ACT_INSERT);
                  idx_in   = TOP_IDX;
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (place) begin
               cmd.wr_en = 1'b1;
               ins_in    = 1'b0;
               added_in  = 1'b1;
            end else if (hit) begin
               x_in = x_ff ^ rd_data;
            end
            if ((place || rd_valid) && !acc_ff[idx_ff]) begin
               acc_in = acc_ff ^ eff;
            end
            if (idx_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
      ins_ff   <= ins_in;
      added_ff <= added_in;
   end

   assign wr_addr   = idx_ff;
   assign wr_data   = x_ff;
   assign res_max   = acc_ff;
   assign res_added = added_ff;

endmodule

@@ design/xor_linear_basis_top.sv @@
// xor linear basis: one gf(2) basis slot per bit, insert, query and clear
// one request at a time: req_ready is high only while the walk is idle
// the walk reads one memory slot per cycle from the top bit down
// reset: synchronous, empties the basis at once through per-slot valid bits
`timescale 1ns / 1ps

module xor_linear_basis_top #(
   parameter int WORD_BITS = xlb_pkg::WORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [xlb_pkg::ACTION_W-1:0]  req_action,
   input  logic [xlb_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [xlb_pkg::MAX_XOR_W-1:0] rsp_max_xor,
   output logic                          rsp_added
);
   import xlb_pkg::*;

   localparam int AW = $clog2(WORD_BITS);

   xlb_slot_cmd_type     cmd;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 rd_valid;
   logic                 idle;
   logic                 start;
   logic [WORD_BITS-1:0] start_word;
   logic                 res_valid;
   logic                 res_ready;
   logic [WORD_BITS-1:0] res_max;
   logic                 res_added;
   logic [MAX_XOR_W-1:0] res_max_out;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MAX_XOR_W-1:0] rsp_max_ff;
   logic                 rsp_added_ff;

   generate
      if (WORD_BITS > VALUE_W) begin : g_in_wide
         assign start_word = {{(WORD_BITS - VALUE_W){1'b0}}, req_value};
      end else if (WORD_BITS == VALUE_W) begin : g_in_same
         assign start_word = req_value;
      end else begin : g_in_narrow
         assign start_word = req_value[WORD_BITS-1:0];
      end
      if (WORD_BITS > MAX_XOR_W) begin : g_out_wide
         assign res_max_out = res_max[MAX_XOR_W-1:0];
      end else if (WORD_BITS == MAX_XOR_W) begin : g_out_same
         assign res_max_out = res_max;
      end else begin : g_out_narrow
         assign res_max_out = {{(MAX_XOR_W - WORD_BITS){1'b0}}, res_max};
      end
   endgenerate

   assign req_ready = idle;
   assign start     = req_valid & idle;

   xlb_slot_store #(
      .WORD_BITS (WORD_BITS),
      .AW        (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .rd_valid (rd_valid)
   );

   xlb_walk #(
      .WORD_BITS (WORD_BITS),
      .AW        (AW)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .start_action (req_action),
      .start_word   (start_word),
      .idle         (idle),
      .cmd          (cmd),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rd_valid     (rd_valid),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_max      (res_max),
      .res_added    (res_added)
   );

   // output register parts the walk from the result channel
   assign res_ready    = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid_in = (res_valid & res_ready) | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_max_ff   <= res_max_out;
         rsp_added_ff <= res_added;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_max_xor = rsp_max_ff;
   assign rsp_added   = rsp_added_ff;

endmodule
